FILE: hw/rtl/assert_macros.svh
// assertion macros for the rtl files, included by the classifier top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define ASSERT_IMPLY(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/atsc_pkg.sv
// constants, register indexes and arctangent table for the tilt classifier
`timescale 1ns / 1ps

package atsc_pkg;

    localparam int ADC_BITS      = 10;
    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 8;
    localparam int GUARD         = 24;
    localparam int ANG_FRAC      = 24;
    localparam int TAB_LEN       = 24;

    localparam int DIFF_W  = ADC_BITS + 1;
    localparam int NUM_W   = ADC_BITS + 8;
    localparam int REM_W   = ADC_BITS + 1;
    localparam int MAP_W   = NUM_W + 2;
    localparam int CW      = NUM_W + GUARD + 3;
    localparam int ZW      = ANG_FRAC + 10;
    localparam int TILT_W  = FRAC_BITS + 8;
    localparam int OUT_W   = 16;
    localparam int THR_W   = 8;
    localparam int CFG_W   = ADC_BITS;
    localparam int IDX_W   = 3;
    localparam int SEL_W   = 2;
    localparam int TONE_W  = 9;
    localparam int PROD_W  = 20;
    localparam int RECIP_SH = 29;
    localparam longint RECIP = (64'd1 << RECIP_SH) / 1023 + 1;

    typedef enum logic [IDX_W-1:0] {
        REG_MIN   = 3'd0,
        REG_MAX   = 3'd1,
        REG_RIGHT = 3'd2,
        REG_LEFT  = 3'd3,
        REG_FWD   = 3'd4,
        REG_BACK  = 3'd5
    } reg_idx_t;

    typedef enum logic [SEL_W-1:0] {
        STEER_STRAIGHT = 2'd0,
        STEER_RIGHT    = 2'd1,
        STEER_LEFT     = 2'd2
    } steer_t;

    typedef enum logic [SEL_W-1:0] {
        DRIVE_STOP = 2'd0,
        DRIVE_FWD  = 2'd1,
        DRIVE_BACK = 2'd2
    } drive_t;

    typedef logic [31:0] ang_tab_t [0:TAB_LEN-1];

    localparam ang_tab_t ATAN_TAB = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115
    };

endpackage

FILE: hw/rtl/accel_tilt_steering_classifier_top.sv
// tilt classifier: axis map, pipelined divide, three cordic units, classify
//
//   channel  | direction | signals
//   in       | in        | in_valid, in_ready, x_raw, y_raw, z_raw
//   out      | out       | out_valid, out_ready, tilt_*, steer, drive, lamps, tone_*
//   cfg      | in        | cfg_we, cfg_index, cfg_data
//
// one word per cycle while the output word is not held; the pipeline depth is set by the
// one-bit-per-stage divider and the unrolled cordic stages.
// reset clears the stage valid bits and loads the default registers.
// a held output word freezes the whole pipeline; in_ready drops in that cycle.
`timescale 1ns / 1ps

module accel_tilt_steering_classifier_top
    import atsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ADC_BITS-1:0]   x_raw,
    input  logic [ADC_BITS-1:0]   y_raw,
    input  logic [ADC_BITS-1:0]   z_raw,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_W-1:0]      tilt_x,
    output logic [OUT_W-1:0]      tilt_y,
    output logic [OUT_W-1:0]      tilt_z,
    output logic [SEL_W-1:0]      steer,
    output logic [SEL_W-1:0]      drive,
    output logic                  left_lamp,
    output logic                  right_lamp,
    output logic                  forward_lamp,
    output logic                  back_lamp,
    output logic [TONE_W-1:0]     tone_freq,
    output logic [TONE_W-1:0]     tone_ms,
    input  logic                  cfg_we,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

`include "assert_macros.svh"

    localparam int NST = NUM_W + CORDIC_STAGES + 4;
    localparam int MAP_S = NUM_W + 1;
    localparam int FIN_S = NUM_W + CORDIC_STAGES + 2;

    logic [ADC_BITS-1:0] min_reg, max_reg;
    logic [THR_W-1:0]    right_reg, left_reg, fwd_reg, back_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= ADC_BITS'(265);
            max_reg   <= ADC_BITS'(402);
            right_reg <= THR_W'(150);
            left_reg  <= THR_W'(30);
            fwd_reg   <= THR_W'(155);
            back_reg  <= THR_W'(25);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN:   min_reg   <= cfg_data[ADC_BITS-1:0];
                REG_MAX:   max_reg   <= cfg_data[ADC_BITS-1:0];
                REG_RIGHT: right_reg <= cfg_data[THR_W-1:0];
                REG_LEFT:  left_reg  <= cfg_data[THR_W-1:0];
                REG_FWD:   fwd_reg   <= cfg_data[THR_W-1:0];
                REG_BACK:  back_reg  <= cfg_data[THR_W-1:0];
                default:   ;
            endcase
        end
    end

    // clamped span
    logic signed [DIFF_W-1:0] span_s;
    logic [ADC_BITS-1:0]      span;
    assign span_s = $signed({1'b0, max_reg}) - $signed({1'b0, min_reg});
    assign span   = (span_s < 1) ? ADC_BITS'(1) : span_s[ADC_BITS-1:0];

    // pipeline control
    logic [NST-1:0] vld_reg, vld_next;
    logic           adv;
    assign adv      = !vld_reg[NST-1] || out_ready;
    assign in_ready = adv;
    assign out_valid = vld_reg[NST-1];
    assign vld_next = {vld_reg[NST-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // entry: magnitude of (raw - min) * 180 and its sign
    logic [ADC_BITS-1:0] raw_in [0:2];
    assign raw_in[0] = x_raw;
    assign raw_in[1] = y_raw;
    assign raw_in[2] = z_raw;

    logic [REM_W-1:0] rem_reg [0:NUM_W][0:2];
    logic [NUM_W-1:0] nq_reg  [0:NUM_W][0:2];
    logic             sgn_reg [0:NUM_W][0:2];

    genvar a, k, i, c;
    generate
        for (a = 0; a < 3; a++)
        begin : g_entry
            logic signed [DIFF_W-1:0] diff;
            logic [ADC_BITS-1:0]      dmag;
            assign diff = $signed({1'b0, raw_in[a]}) - $signed({1'b0, min_reg});
            assign dmag = diff[DIFF_W-1] ? ADC_BITS'(-diff) : diff[ADC_BITS-1:0];
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[0][a] <= '0;
                    nq_reg[0][a]  <= NUM_W'(dmag) * NUM_W'(180);
                    sgn_reg[0][a] <= diff[DIFF_W-1];
                end
            end
        end

        // restoring divide, one quotient bit per stage
        for (k = 0; k < NUM_W; k++)
        begin : g_div
            for (a = 0; a < 3; a++)
            begin : g_ax
                logic [REM_W:0] t;
                logic           ge;
                assign t  = {rem_reg[k][a], nq_reg[k][a][NUM_W-1]};
                assign ge = t >= (REM_W+1)'(span);
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        rem_reg[k+1][a] <= ge ? REM_W'(t - (REM_W+1)'(span)) : t[REM_W-1:0];
                        nq_reg[k+1][a]  <= {nq_reg[k][a][NUM_W-2:0], ge};
                        sgn_reg[k+1][a] <= sgn_reg[k][a];
                    end
                end
            end
        end
    endgenerate

    // mapped axes: magnitude and sign
    logic signed [MAP_W-1:0] mapped [0:2];
    logic [NUM_W-1:0]        mmag   [0:2];
    logic                    mpos   [0:2];
    generate
        for (a = 0; a < 3; a++)
        begin : g_map
            logic signed [MAP_W-1:0] q;
            assign q = $signed({2'b00, nq_reg[NUM_W][a]});
            assign mapped[a] = (sgn_reg[NUM_W][a] ? -q : q) - MAP_W'(90);
            assign mmag[a] = mapped[a][MAP_W-1] ? NUM_W'(-mapped[a])
                                                : mapped[a][NUM_W-1:0];
            assign mpos[a] = !mapped[a][MAP_W-1] && (mapped[a] != 0);
        end
    endgenerate

    // cordic units: 0 tilt_x (y over z), 1 tilt_y (x over z), 2 tilt_z (y over x)
    logic [NUM_W-1:0] ca_mag [0:2];
    logic [NUM_W-1:0] cb_mag [0:2];
    logic             cb_pos [0:2];
    assign ca_mag[0] = mmag[1]; assign cb_mag[0] = mmag[2]; assign cb_pos[0] = mpos[2];
    assign ca_mag[1] = mmag[0]; assign cb_mag[1] = mmag[2]; assign cb_pos[1] = mpos[2];
    assign ca_mag[2] = mmag[1]; assign cb_mag[2] = mmag[0]; assign cb_pos[2] = mpos[0];

    logic signed [CW-1:0] cx_reg [0:CORDIC_STAGES][0:2];
    logic signed [CW-1:0] cy_reg [0:CORDIC_STAGES][0:2];
    logic signed [ZW-1:0] cz_reg [0:CORDIC_STAGES][0:2];
    logic                 az_reg [0:CORDIC_STAGES][0:2];
    logic                 bz_reg [0:CORDIC_STAGES][0:2];
    logic                 ng_reg [0:CORDIC_STAGES][0:2];

    logic [TILT_W-1:0] tilt_reg [0:2];

    generate
        for (c = 0; c < 3; c++)
        begin : g_cinit
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    cx_reg[0][c] <= $signed(CW'(cb_mag[c]) << GUARD);
                    cy_reg[0][c] <= $signed(CW'(ca_mag[c]) << GUARD);
                    cz_reg[0][c] <= '0;
                    az_reg[0][c] <= ca_mag[c] == '0;
                    bz_reg[0][c] <= cb_mag[c] == '0;
                    ng_reg[0][c] <= cb_pos[c];
                end
            end
        end

        for (i = 0; i < CORDIC_STAGES; i++)
        begin : g_cordic
            for (c = 0; c < 3; c++)
            begin : g_unit
                logic signed [CW-1:0] dx, dy;
                logic signed [ZW-1:0] ang;
                assign dx  = cy_reg[i][c] >>> i;
                assign dy  = cx_reg[i][c] >>> i;
                assign ang = $signed(ZW'(ATAN_TAB[i]));
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        if (cy_reg[i][c] > 0)
                        begin
                            cx_reg[i+1][c] <= cx_reg[i][c] + dx;
                            cy_reg[i+1][c] <= cy_reg[i][c] - dy;
                            cz_reg[i+1][c] <= cz_reg[i][c] + ang;
                        end
                        else if (cy_reg[i][c] < 0)
                        begin
                            cx_reg[i+1][c] <= cx_reg[i][c] - dx;
                            cy_reg[i+1][c] <= cy_reg[i][c] + dy;
                            cz_reg[i+1][c] <= cz_reg[i][c] - ang;
                        end
                        else
                        begin
                            cx_reg[i+1][c] <= cx_reg[i][c];
                            cy_reg[i+1][c] <= cy_reg[i][c];
                            cz_reg[i+1][c] <= cz_reg[i][c];
                        end
                        az_reg[i+1][c] <= az_reg[i][c];
                        bz_reg[i+1][c] <= bz_reg[i][c];
                        ng_reg[i+1][c] <= ng_reg[i][c];
                    end
                end
            end
        end

        // clamp, round, fold into 0..180
        for (c = 0; c < 3; c++)
        begin : g_fin
            localparam logic signed [ZW-1:0] ZMAX = ZW'(90) << ANG_FRAC;
            logic signed [ZW-1:0] zc;
            logic [ZW-1:0]        zr;
            logic [TILT_W-1:0]    th, half, res;
            assign zc   = (cz_reg[CORDIC_STAGES][c] < 0) ? '0 :
                          (cz_reg[CORDIC_STAGES][c] > ZMAX) ? ZMAX :
                          cz_reg[CORDIC_STAGES][c];
            assign zr   = ($unsigned(zc) + (ZW'(1) << (ANG_FRAC-1-FRAC_BITS)))
                          >> (ANG_FRAC-FRAC_BITS);
            assign half = TILT_W'(180) << FRAC_BITS;
            assign th   = bz_reg[CORDIC_STAGES][c] ? (TILT_W'(90) << FRAC_BITS)
                                                   : zr[TILT_W-1:0];
            assign res  = az_reg[CORDIC_STAGES][c] ?
                              (ng_reg[CORDIC_STAGES][c] ? half : '0) :
                              (ng_reg[CORDIC_STAGES][c] ? half - th : th);
            always_ff @(posedge clk)
            begin
                if (adv)
                    tilt_reg[c] <= res;
            end
        end
    endgenerate

    // classify, lamps, tone
    logic [TILT_W-1:0]  tx, tz;
    logic [SEL_W-1:0]   steer_c, drive_c;
    logic [TONE_W-1:0]  s_val;
    logic [PROD_W+RECIP_SH-1:0] p_mul;
    logic [TONE_W-1:0]  freq_c, ms_c;
    logic [TILT_W+1:0]  lim, tx2;

    assign tx = tilt_reg[0];
    assign tz = tilt_reg[2];

    always_comb
    begin
        if (tz >= (TILT_W'(right_reg) << FRAC_BITS))
            steer_c = STEER_RIGHT;
        else if (tz <= (TILT_W'(left_reg) << FRAC_BITS))
            steer_c = STEER_LEFT;
        else
            steer_c = STEER_STRAIGHT;
        if (tx >= (TILT_W'(fwd_reg) << FRAC_BITS))
            drive_c = DRIVE_FWD;
        else if (tx <= (TILT_W'(back_reg) << FRAC_BITS))
            drive_c = DRIVE_BACK;
        else
            drive_c = DRIVE_STOP;
    end

    // times 900 and divide by 1023 as one reciprocal multiply, exact for this range
    assign s_val  = TONE_W'(({1'b0, tz} << 1) >> FRAC_BITS);
    assign p_mul  = (PROD_W+RECIP_SH)'(s_val) * (PROD_W+RECIP_SH)'(RECIP * 900);
    assign freq_c = TONE_W'((p_mul >> RECIP_SH) + 7'd100);
    assign lim    = (TILT_W+2)'(400) << FRAC_BITS;
    assign tx2    = (TILT_W+2)'(tx) << 1;
    assign ms_c   = (tx2 <= lim) ? TONE_W'((lim - tx2) >> FRAC_BITS) : '0;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tilt_x       <= OUT_W'(tilt_reg[0]);
            tilt_y       <= OUT_W'(tilt_reg[1]);
            tilt_z       <= OUT_W'(tilt_reg[2]);
            steer        <= steer_c;
            drive        <= drive_c;
            left_lamp    <= steer_c != STEER_RIGHT;
            right_lamp   <= steer_c != STEER_LEFT;
            forward_lamp <= drive_c != DRIVE_BACK;
            back_lamp    <= drive_c != DRIVE_FWD;
            tone_freq    <= freq_c;
            tone_ms      <= ms_c;
        end
    end

    `ASSERT_NEXT(a_stall_freezes, !adv, $stable(vld_reg))
    `ASSERT_NEXT(a_last_moves_out, adv && vld_reg[NST-2], out_valid)
    `ASSERT_IMPLY(a_lamps_not_both_off, out_valid, left_lamp || right_lamp)
    `ASSERT_IMPLY(a_tone_range, out_valid, tone_freq >= 9'd100 && tone_freq <= 9'd416)
    `ASSERT_IMPLY(a_tilt_range, vld_reg[FIN_S],
                  tilt_reg[0] <= (TILT_W'(180) << FRAC_BITS) && vld_reg[MAP_S-1+1] == vld_reg[MAP_S])

endmodule
